/* design/hgcd_pkg.sv */
package hgcd_pkg;

   localparam int ANGLE_W = 32;
   localparam int DIST_W = 36;
   localparam int RAD_W = 26;
   localparam int CSR_W = 32;
   localparam int REQ_DATA_W = 4 * ANGLE_W;
   localparam int RSP_DATA_W = ((DIST_W + 7) / 8) * 8;

   localparam int ANG_Q_W = ANGLE_W + 2;
   localparam int RED_W = ANG_Q_W + 2;
   localparam int CORD_W = 34;
   localparam int TRIG_W = 33;
   localparam int STEPS = 32;

   localparam int MUL_W = 2 * TRIG_W;
   localparam int CC_W = MUL_W - 30;
   localparam int T1_W = CC_W + TRIG_W + 1;
   localparam int T_W = T1_W - 30;
   localparam int T2_W = T_W + TRIG_W + 1;
   localparam int HS_W = T2_W + 1;
   localparam int H_W = 61;
   localparam int ROOT_W = 31;
   localparam int ACC_W = H_W + 1;
   localparam int SCL_W = RAD_W + ROOT_W;
   localparam int RND_W = SCL_W + 1;
   localparam int QUO_W = RND_W - 21;

   localparam int SC_STAGES = STEPS + 3;
   localparam int ISQ_STAGES = (H_W + 1) / 2;
   localparam int AT_STAGES = STEPS;
   localparam int DEPTH = 1 + SC_STAGES + 4 + ISQ_STAGES + AT_STAGES + 2;

   localparam logic signed [RED_W-1:0] K_PI = 36'sd3373259426;
   localparam logic signed [RED_W-1:0] K_HALF_PI = 36'sd1686629713;
   localparam logic signed [RED_W-1:0] K_TWO_PI = 36'sd6746518852;
   localparam logic signed [CORD_W-1:0] K_GAIN = 34'sd652032874;
   localparam logic [H_W-1:0] H_ONE = H_W'(1) << 60;

   localparam logic [29:0] ATAN_TAB [0:STEPS-1] = '{
      30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
      30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
      30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
      30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
      30'd127, 30'd63, 30'd31, 30'd15, 30'd8, 30'd4, 30'd2, 30'd1, 30'd0
   };

   typedef enum logic [1:0] {
      CSR_RADIUS  = 2'd0,
      CSR_FIX_EN  = 2'd1,
      CSR_FIX_LAT = 2'd2,
      CSR_FIX_LON = 2'd3
   } csr_index_type;

endpackage

/* design/hgcd_ctrl.sv */
module hgcd_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic rsp_tready,
   output logic req_tready,
   output logic rsp_tvalid,
   output logic advance
);
   import hgcd_pkg::*;

   logic [DEPTH-1:0] v_ff;
   logic [DEPTH-1:0] v_in;

   always_comb begin
      advance = !v_ff[DEPTH-1] || rsp_tready;
      v_in = {v_ff[DEPTH-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= v_in;
      end
   end

   assign req_tready = advance;
   assign rsp_tvalid = v_ff[DEPTH-1];

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (v_ff[DEPTH-1] && !rsp_tready) |-> !req_tready)
      else $error("input taken while the result stage is stalled");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v_ff[0])
      else $error("accepted transfer did not enter the first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(v_ff))
      else $error("valid bits moved during a stall");

endmodule

/* design/hgcd_sincos.sv */
module hgcd_sincos (
   input  logic                                 clock,
   input  logic                                 advance,
   input  logic signed [hgcd_pkg::ANG_Q_W-1:0]  angle,
   output logic signed [hgcd_pkg::TRIG_W-1:0]   sin_out,
   output logic signed [hgcd_pkg::TRIG_W-1:0]   cos_out
);
   import hgcd_pkg::*;

   logic signed [RED_W-1:0]  wide;
   logic signed [RED_W-1:0]  red_in;
   logic signed [RED_W-1:0]  red_ff;
   logic signed [RED_W-1:0]  fold_in;
   logic                     neg_in;
   logic signed [CORD_W-1:0] x_ff [0:STEPS];
   logic signed [CORD_W-1:0] y_ff [0:STEPS];
   logic signed [CORD_W-1:0] z_ff [0:STEPS];
   logic                     neg_ff [0:STEPS];
   logic signed [CORD_W-1:0] x_in [0:STEPS-1];
   logic signed [CORD_W-1:0] y_in [0:STEPS-1];
   logic signed [CORD_W-1:0] z_in [0:STEPS-1];
   logic signed [TRIG_W-1:0] sin_ff;
   logic signed [TRIG_W-1:0] cos_ff;

   always_comb begin
      wide = RED_W'(angle);
      priority if (wide >= K_PI) begin
         red_in = wide - K_TWO_PI;
      end else if (wide < -K_PI) begin
         red_in = wide + K_TWO_PI;
      end else begin
         red_in = wide;
      end
      priority if (red_ff > K_HALF_PI) begin
         fold_in = red_ff - K_PI;
         neg_in = 1'b1;
      end else if (red_ff < -K_HALF_PI) begin
         fold_in = red_ff + K_PI;
         neg_in = 1'b1;
      end else begin
         fold_in = red_ff;
         neg_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff <= red_in;
         x_ff[0] <= K_GAIN;
         y_ff[0] <= '0;
         z_ff[0] <= CORD_W'(fold_in);
         neg_ff[0] <= neg_in;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      always_comb begin
         if (!z_ff[i][CORD_W-1]) begin
            x_in[i] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i] = z_ff[i] - CORD_W'(ATAN_TAB[i]);
         end else begin
            x_in[i] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i] = z_ff[i] + CORD_W'(ATAN_TAB[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i+1] <= x_in[i];
            y_ff[i+1] <= y_in[i];
            z_ff[i+1] <= z_in[i];
            neg_ff[i+1] <= neg_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sin_ff <= TRIG_W'(neg_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS]);
         cos_ff <= TRIG_W'(neg_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS]);
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule

/* design/hgcd_isqrt.sv */
module hgcd_isqrt (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [hgcd_pkg::H_W-1:0]      radicand,
   output logic [hgcd_pkg::ROOT_W-1:0]   root
);
   import hgcd_pkg::*;

   logic [H_W-1:0]   n_src [0:ISQ_STAGES];
   logic [ACC_W-1:0] r_src [0:ISQ_STAGES];
   logic [H_W-1:0]   n_ff [0:ISQ_STAGES-1];
   logic [ACC_W-1:0] r_ff [0:ISQ_STAGES-1];

   assign n_src[0] = radicand;
   assign r_src[0] = '0;

   for (genvar j = 0; j < ISQ_STAGES; j++) begin : g_digit
      logic [ACC_W-1:0] bit_c;
      logic [ACC_W-1:0] trial;
      logic [H_W-1:0]   n_in;
      logic [ACC_W-1:0] r_in;

      assign bit_c = ACC_W'(1) << (H_W - 1 - 2 * j);

      always_comb begin
         trial = r_src[j] + bit_c;
         if (ACC_W'(n_src[j]) >= trial) begin
            n_in = H_W'(ACC_W'(n_src[j]) - trial);
            r_in = (r_src[j] >> 1) + bit_c;
         end else begin
            n_in = n_src[j];
            r_in = r_src[j] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            n_ff[j] <= n_in;
            r_ff[j] <= r_in;
         end
      end

      assign n_src[j+1] = n_ff[j];
      assign r_src[j+1] = r_ff[j];
   end

   assign root = r_src[ISQ_STAGES][ROOT_W-1:0];

endmodule

/* design/hgcd_atan2.sv */
module hgcd_atan2 (
   input  logic                               clock,
   input  logic                               advance,
   input  logic [hgcd_pkg::ROOT_W-1:0]        y_root,
   input  logic [hgcd_pkg::ROOT_W-1:0]        x_root,
   output logic signed [hgcd_pkg::CORD_W-1:0] theta
);
   import hgcd_pkg::*;

   logic signed [CORD_W-1:0] x_src [0:STEPS];
   logic signed [CORD_W-1:0] y_src [0:STEPS];
   logic signed [CORD_W-1:0] z_src [0:STEPS];
   logic signed [CORD_W-1:0] x_ff [0:STEPS-1];
   logic signed [CORD_W-1:0] y_ff [0:STEPS-1];
   logic signed [CORD_W-1:0] z_ff [0:STEPS-1];

   assign x_src[0] = CORD_W'(x_root);
   assign y_src[0] = CORD_W'(y_root);
   assign z_src[0] = '0;

   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      logic signed [CORD_W-1:0] x_in;
      logic signed [CORD_W-1:0] y_in;
      logic signed [CORD_W-1:0] z_in;

      always_comb begin
         if (y_src[i][CORD_W-1]) begin
            x_in = x_src[i] - (y_src[i] >>> i);
            y_in = y_src[i] + (x_src[i] >>> i);
            z_in = z_src[i] - CORD_W'(ATAN_TAB[i]);
         end else begin
            x_in = x_src[i] + (y_src[i] >>> i);
            y_in = y_src[i] - (x_src[i] >>> i);
            z_in = z_src[i] + CORD_W'(ATAN_TAB[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            z_ff[i] <= z_in;
         end
      end

      assign x_src[i+1] = x_ff[i];
      assign y_src[i+1] = y_ff[i];
      assign z_src[i+1] = z_ff[i];
   end

   assign theta = z_src[STEPS];

endmodule

/* design/haversine_great_circle_distance.sv */
// Haversine great-circle distance engine. Each req transfer carries a start and an end
// point in signed radians (2^-29 rad), the start taken from the fix registers when fix
// is enabled; each rsp transfer returns 2*R*asin(sqrt(h)) in 2^-8 m, saturating at
// all ones, with tlast copied from the request. The pipeline takes one pair per cycle
// while the result stage is empty or its result is taken; its depth is set by the
// 35-stage sine/cosine CORDIC lanes, the 31-stage square root lanes and the 32-stage
// arctangent CORDIC. When the result is not taken the whole pipeline holds. Configuration
// writes are taken in any cycle and should be made while no transfer is in flight.
module haversine_great_circle_distance (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // start_lat, start_lon, end_lat, end_lon
   input  logic [hgcd_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // distance, zero fill
   output logic [hgcd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic [1:0]                          csr_addr,
   input  logic [hgcd_pkg::CSR_W-1:0]          csr_wr_data
);
   import hgcd_pkg::*;

   logic                       advance;
   logic [RAD_W-1:0]           radius_ff;
   logic                       fix_en_ff;
   logic signed [ANGLE_W-1:0]  fix_lat_ff;
   logic signed [ANGLE_W-1:0]  fix_lon_ff;

   logic signed [ANGLE_W-1:0]  lat1;
   logic signed [ANGLE_W-1:0]  lon1;
   logic signed [ANGLE_W-1:0]  lat2;
   logic signed [ANGLE_W-1:0]  lon2;
   logic signed [ANG_Q_W-1:0]  dlat_ff;
   logic signed [ANG_Q_W-1:0]  dlon_ff;
   logic signed [ANG_Q_W-1:0]  lat1_ff;
   logic signed [ANG_Q_W-1:0]  lat2_ff;

   logic signed [TRIG_W-1:0]   s1;
   logic signed [TRIG_W-1:0]   s2;
   logic signed [TRIG_W-1:0]   c1;
   logic signed [TRIG_W-1:0]   c2;
   logic signed [TRIG_W-1:0]   unused_c_dlat;
   logic signed [TRIG_W-1:0]   unused_c_dlon;
   logic signed [TRIG_W-1:0]   unused_s_lat1;
   logic signed [TRIG_W-1:0]   unused_s_lat2;

   logic signed [MUL_W-1:0]    s1sq_a_ff;
   logic signed [MUL_W-1:0]    s1sq_b_ff;
   logic signed [MUL_W-1:0]    s1sq_c_ff;
   logic signed [MUL_W-1:0]    ccp_ff;
   logic signed [TRIG_W-1:0]   s2_a_ff;
   logic signed [TRIG_W-1:0]   s2_b_ff;
   logic signed [CC_W-1:0]     cc;
   logic signed [T1_W-1:0]     t1_ff;
   logic signed [T_W-1:0]      t;
   logic signed [T2_W-1:0]     t2_ff;
   logic signed [HS_W-1:0]     h_sum;
   logic [H_W-1:0]             h_in;
   logic [H_W-1:0]             h_ff;
   logic [H_W-1:0]             hc_ff;

   logic [ROOT_W-1:0]          sy;
   logic [ROOT_W-1:0]          sx;
   logic signed [CORD_W-1:0]   theta;
   logic [ROOT_W-1:0]          theta_pos;
   logic [SCL_W-1:0]           scale_ff;
   logic [RND_W-1:0]           rnd;
   logic [QUO_W-1:0]           quo;
   logic [DIST_W-1:0]          dist_in;
   logic [DIST_W-1:0]          dist_ff;
   logic                       last_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RAD_W'(6371000);
         fix_en_ff <= 1'b0;
         fix_lat_ff <= '0;
         fix_lon_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_addr))
            CSR_RADIUS:  radius_ff <= csr_wr_data[RAD_W-1:0];
            CSR_FIX_EN:  fix_en_ff <= csr_wr_data[0];
            CSR_FIX_LAT: fix_lat_ff <= csr_wr_data[ANGLE_W-1:0];
            CSR_FIX_LON: fix_lon_ff <= csr_wr_data[ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   hgcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_tready (rsp_tready),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .advance    (advance)
   );

   always_comb begin
      lat1 = fix_en_ff ? fix_lat_ff : req_tdata[ANGLE_W-1:0];
      lon1 = fix_en_ff ? fix_lon_ff : req_tdata[2*ANGLE_W-1:ANGLE_W];
      lat2 = req_tdata[3*ANGLE_W-1:2*ANGLE_W];
      lon2 = req_tdata[4*ANGLE_W-1:3*ANGLE_W];
   end

   // Differences stay Q29 and are not shifted, so read as Q30 they give the half angles.
   always_ff @(posedge clock) begin
      if (advance) begin
         dlat_ff <= ANG_Q_W'(lat2) - ANG_Q_W'(lat1);
         dlon_ff <= ANG_Q_W'(lon2) - ANG_Q_W'(lon1);
         lat1_ff <= ANG_Q_W'(lat1) <<< 1;
         lat2_ff <= ANG_Q_W'(lat2) <<< 1;
      end
   end

   hgcd_sincos u_sc_dlat (
      .clock (clock), .advance (advance), .angle (dlat_ff),
      .sin_out (s1), .cos_out (unused_c_dlat)
   );

   hgcd_sincos u_sc_dlon (
      .clock (clock), .advance (advance), .angle (dlon_ff),
      .sin_out (s2), .cos_out (unused_c_dlon)
   );

   hgcd_sincos u_sc_lat1 (
      .clock (clock), .advance (advance), .angle (lat1_ff),
      .sin_out (unused_s_lat1), .cos_out (c1)
   );

   hgcd_sincos u_sc_lat2 (
      .clock (clock), .advance (advance), .angle (lat2_ff),
      .sin_out (unused_s_lat2), .cos_out (c2)
   );

   always_comb begin
      cc = CC_W'(ccp_ff >>> 30);
      t = T_W'(t1_ff >>> 30);
      h_sum = HS_W'(s1sq_c_ff) + HS_W'(t2_ff);
      priority if (h_sum[HS_W-1]) begin
         h_in = '0;
      end else if (h_sum > HS_W'(H_ONE)) begin
         h_in = H_ONE;
      end else begin
         h_in = h_sum[H_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1sq_a_ff <= MUL_W'(s1) * MUL_W'(s1);
         ccp_ff <= MUL_W'(c1) * MUL_W'(c2);
         s2_a_ff <= s2;
         s1sq_b_ff <= s1sq_a_ff;
         t1_ff <= T1_W'(cc) * T1_W'(s2_a_ff);
         s2_b_ff <= s2_a_ff;
         s1sq_c_ff <= s1sq_b_ff;
         t2_ff <= T2_W'(t) * T2_W'(s2_b_ff);
         h_ff <= h_in;
         hc_ff <= H_ONE - h_in;
      end
   end

   hgcd_isqrt u_sqrt_y (
      .clock (clock), .advance (advance), .radicand (h_ff), .root (sy)
   );

   hgcd_isqrt u_sqrt_x (
      .clock (clock), .advance (advance), .radicand (hc_ff), .root (sx)
   );

   hgcd_atan2 u_atan2 (
      .clock (clock), .advance (advance), .y_root (sy), .x_root (sx), .theta (theta)
   );

   always_comb begin
      theta_pos = theta[CORD_W-1] ? '0 : theta[ROOT_W-1:0];
      rnd = RND_W'(scale_ff) + (RND_W'(1) << 20);
      quo = rnd[RND_W-1:21];
      dist_in = (quo > QUO_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : quo[DIST_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         scale_ff <= SCL_W'(radius_ff) * SCL_W'(theta_pos);
         dist_ff <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last_ff[0] <= req_tlast;
      end
   end

   for (genvar k = 1; k < DEPTH; k++) begin : g_last
      always_ff @(posedge clock) begin
         if (advance) begin
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   assign rsp_tdata = RSP_DATA_W'(dist_ff);
   assign rsp_tlast = last_ff[DEPTH-1];

endmodule
